>>> rtl/modexp_pkg.sv
// modexp_pkg: widths, step counts and sequencer state codes for the modular
// exponentiation unit
// no dependencies
package modexp_pkg;

   localparam int BASE_WIDTH = 32;
   localparam int EXP_WIDTH  = 32;
   localparam int MOD_WIDTH  = 31;

   // one shift-add-reduce step per bit of the wider multiplier operand
   localparam int MUL_STEPS  = BASE_WIDTH;
   localparam int CNT_WIDTH  = $clog2(MUL_STEPS);

   // running sum width: 2r + b stays below 3m
   localparam int SUM_WIDTH  = MOD_WIDTH + 2;

   localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(2);
   localparam logic [MOD_WIDTH-1:0] ONE       = MOD_WIDTH'(1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_SQUARE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

>>> rtl/modular_exponentiation_unit.sv
// modular_exponentiation_unit: base^exponent mod modulus by right-to-left
// square-and-multiply on one shared bit-serial modular multiplier
// depends on modexp_pkg
//
// Each request carries a base and an exponent and yields one response holding
// base^exponent mod modulus, where the modulus comes from the csr register
// (reset value 2). All arithmetic runs on a single shift-add-reduce modular
// multiplier that consumes one multiplier bit per cycle. The base is first
// reduced (one pass of the unit), then for each exponent bit from the lsb
// upward the accumulator is multiplied by the running power when the bit is
// set, and the power is squared while higher set bits remain. A request
// therefore takes 1 + popcount(exponent) + position of highest set bit passes
// of the multiplier. A zero exponent answers 1 (and a modulus below 2 answers
// 0) without a pass of the multiplier.
// req_tready is high only while the sequencer is idle; a finished response
// sits in its own output register, so the next request can be taken while the
// previous response waits for rsp_tready. The modulus may only be written while
// no request is in flight.
module modular_exponentiation_unit
   import modexp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] base_value, [63:32] exponent

   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [30:0] residue, [31] zero

   // modulus register
   input  logic                 csr_wr_en,
   input  logic [MOD_WIDTH-1:0] csr_wr_data
);

   // sequencer and operand registers
   state_type              state_ff,   state_in;
   logic [MOD_WIDTH-1:0]   mod_ff,     mod_in;
   logic [EXP_WIDTH-1:0]   exp_ff,     exp_in;
   logic [MOD_WIDTH-1:0]   acc_ff,     acc_in;
   logic [MOD_WIDTH-1:0]   pow_ff,     pow_in;

   // shared modular multiplier: r = a * b mod m, a scanned msb first
   logic [BASE_WIDTH-1:0]  mul_a_ff,   mul_a_in;
   logic [MOD_WIDTH-1:0]   mul_b_ff,   mul_b_in;
   logic [MOD_WIDTH-1:0]   mul_r_ff,   mul_r_in;
   logic [CNT_WIDTH-1:0]   mul_cnt_ff, mul_cnt_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0]   rsp_data_ff,  rsp_data_in;

   // multiplier datapath
   logic [SUM_WIDTH-1:0]   mul_sum;
   logic [SUM_WIDTH:0]     mul_sub1;
   logic [SUM_WIDTH:0]     mul_sub2;
   logic [MOD_WIDTH-1:0]   mul_next;
   logic                   mul_last;

   logic                   req_fire;
   logic [BASE_WIDTH-1:0]  req_base;
   logic [EXP_WIDTH-1:0]   req_exp;
   logic [EXP_WIDTH-1:0]   exp_shift;
   logic                   rsp_free;

   assign req_base   = req_tdata[BASE_WIDTH-1:0];
   assign req_exp    = req_tdata[BASE_WIDTH +: EXP_WIDTH];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};
   // output register can take a new response this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign exp_shift  = exp_ff >> 1;

   // one interleaved step: 2r + bit*b, then subtract m or 2m as needed
   always_comb begin
      mul_sum  = {1'b0, mul_r_ff, 1'b0}
               + (mul_a_ff[BASE_WIDTH-1] ? {2'b00, mul_b_ff} : '0);
      mul_sub1 = {1'b0, mul_sum} - {3'b000, mod_ff};
      mul_sub2 = {1'b0, mul_sum} - {2'b00, mod_ff, 1'b0};
      if (!mul_sub2[SUM_WIDTH]) begin
         mul_next = mul_sub2[MOD_WIDTH-1:0];
      end else if (!mul_sub1[SUM_WIDTH]) begin
         mul_next = mul_sub1[MOD_WIDTH-1:0];
      end else begin
         mul_next = mul_sum[MOD_WIDTH-1:0];
      end
   end

   assign mul_last = (mul_cnt_ff == CNT_WIDTH'(MUL_STEPS - 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      pow_in       = pow_ff;
      mul_a_in     = mul_a_ff << 1;
      mul_b_in     = mul_b_ff;
      mul_r_in     = mul_next;
      mul_cnt_in   = mul_cnt_ff + CNT_WIDTH'(1);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         mod_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               exp_in     = req_exp;
               mul_a_in   = req_base;
               mul_b_in   = ONE;
               mul_r_in   = '0;
               mul_cnt_in = '0;
               if (req_exp == '0) begin
                  // zero exponent answers one for any modulus
                  acc_in   = ONE;
                  state_in = ST_FINISH;
               end else if (mod_ff < MOD_RESET) begin
                  // degenerate modulus of zero or one
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = ONE;
                  state_in = ST_REDUCE;
               end
            end
         end

         ST_REDUCE: begin
            // base * 1 mod m leaves the reduced base
            if (mul_last) begin
               pow_in     = mul_next;
               mul_r_in   = '0;
               mul_cnt_in = '0;
               if (exp_ff[0]) begin
                  mul_a_in = {1'b0, acc_ff};
                  mul_b_in = mul_next;
                  state_in = ST_MULT;
               end else begin
                  mul_a_in = {1'b0, mul_next};
                  mul_b_in = mul_next;
                  state_in = ST_SQUARE;
               end
            end
         end

         ST_MULT: begin
            if (mul_last) begin
               acc_in     = mul_next;
               mul_r_in   = '0;
               mul_cnt_in = '0;
               if (exp_shift == '0) begin
                  // no higher set bits, result is complete
                  state_in = ST_FINISH;
               end else begin
                  mul_a_in = {1'b0, pow_ff};
                  mul_b_in = pow_ff;
                  state_in = ST_SQUARE;
               end
            end
         end

         ST_SQUARE: begin
            // higher set bits remain here, so the next bit is always visited
            if (mul_last) begin
               pow_in     = mul_next;
               exp_in     = exp_shift;
               mul_r_in   = '0;
               mul_cnt_in = '0;
               mul_b_in   = mul_next;
               if (exp_shift[0]) begin
                  mul_a_in = {1'b0, acc_ff};
                  state_in = ST_MULT;
               end else begin
                  mul_a_in = {1'b0, mul_next};
                  state_in = ST_SQUARE;
               end
            end
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= MOD_RESET;
         rsp_valid_ff <= 1'b0;
         mul_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_cnt_ff   <= mul_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      pow_ff      <= pow_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_r_ff    <= mul_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
